// ===== rtl/fpr_pkg.sv =====
// Shared constants, types and a helper function of the frequency page replacement block.
package fpr_pkg;

  // Sizes of the page table and the frame pool.
  localparam int unsigned NumPages  = 16;
  localparam int unsigned MaxFrames = 8;

  // Field widths.
  localparam int unsigned PageW     = $clog2(NumPages);
  localparam int unsigned CountW    = 16;
  localparam int unsigned TimeW     = 32;
  localparam int unsigned FrameCfgW = 4;
  localparam int unsigned FrameW    = $clog2(MaxFrames + 1);
  localparam int unsigned EntryW    = CountW + TimeW;
  localparam int unsigned CfgIdxW   = 1;
  localparam int unsigned CfgDataW  = FrameCfgW;

  // Saturation value of the reference count.
  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgPolicy = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgFrames = 1'b1;

  // Policy codes.
  localparam logic PolicyLfu = 1'b0;
  localparam logic PolicyMfu = 1'b1;

  // Control of the victim search unit.
  typedef struct packed {
    logic clear;
    logic step;
  } scan_ctrl_t;

  // Saturating increment of a reference count.
  function automatic logic [CountW-1:0] bump(input logic [CountW-1:0] c);
    logic [CountW-1:0] r;
    if (c == CountMax) begin
      r = CountMax;
    end else begin
      r = c + CountW'(1);
    end
    return r;
  endfunction

endpackage

// ===== rtl/fpr_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module fpr_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/fpr_victim_scan.sv =====
// Victim search unit: keeps the best eviction candidate as page records stream by.
module fpr_victim_scan (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  fpr_pkg::scan_ctrl_t        ctrl_i,
  input  logic                       policy_i,
  input  logic [fpr_pkg::TimeW-1:0]  time_now_i,
  input  logic [fpr_pkg::PageW-1:0]  idx_i,
  input  logic                       resident_i,
  input  logic [fpr_pkg::CountW-1:0] count_i,
  input  logic [fpr_pkg::TimeW-1:0]  time_i,
  output logic [fpr_pkg::PageW-1:0]  victim_o
);

  logic                       found_q, found_d;
  logic [fpr_pkg::PageW-1:0]  best_idx_q, best_idx_d;
  logic [fpr_pkg::CountW-1:0] best_count_q, best_count_d;
  logic [fpr_pkg::TimeW-1:0]  best_age_q, best_age_d;
  logic [fpr_pkg::TimeW-1:0]  age;
  logic                       take;

  // Age under wrap is the modular distance to the current time.
  assign age = time_now_i - time_i;

  // Candidate selection: count decides by policy, equal counts go to the older page.
  always_comb begin
    take = 1'b0;
    if (resident_i) begin
      if (!found_q) begin
        take = 1'b1;
      end else if (count_i == best_count_q) begin
        take = age > best_age_q;
      end else if (policy_i == fpr_pkg::PolicyLfu) begin
        take = count_i < best_count_q;
      end else begin
        take = count_i > best_count_q;
      end
    end
  end

  // Next value of the running best.
  always_comb begin
    found_d      = found_q;
    best_idx_d   = best_idx_q;
    best_count_d = best_count_q;
    best_age_d   = best_age_q;
    if (ctrl_i.clear) begin
      found_d = 1'b0;
    end else if (ctrl_i.step && take) begin
      found_d      = 1'b1;
      best_idx_d   = idx_i;
      best_count_d = count_i;
      best_age_d   = age;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else begin
      found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_idx_q   <= best_idx_d;
    best_count_q <= best_count_d;
    best_age_q   <= best_age_d;
  end

  assign victim_o = best_idx_q;

endmodule

// ===== rtl/frequency_page_replacement.sv =====
// Frequency page replacement (LFU or MFU, oldest first on ties): top level.
// A word is taken when start is high and busy is low. Its result is on the result
// ports, marked by done_o high for one cycle, and the receiver cannot stall it. A hit
// or a miss into a free frame goes from the look-up state back to idle; a miss with
// eviction first runs the one-record-per-cycle scan of the page table RAM and then
// the finish state. busy is low in the done_o cycle, so the next word can be taken at the
// edge that takes the result. Reset clears the resident and written flags and the time.
module frequency_page_replacement (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [fpr_pkg::PageW-1:0]     page_i,
  input  logic                          cfg_we_i,
  input  logic [fpr_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [fpr_pkg::CfgDataW-1:0]  cfg_wdata_i,
  output logic                          done_o,
  output logic                          fault_o,
  output logic                          replaced_o,
  output logic [fpr_pkg::PageW-1:0]     victim_page_o,
  output logic [fpr_pkg::CountW-1:0]    ref_count_o
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_LOOK = 4'b0010,
    S_SCAN = 4'b0100,
    S_FIN  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic                              policy_q, policy_d;
  logic [fpr_pkg::FrameCfgW-1:0]     frame_cnt_q, frame_cnt_d;
  logic [fpr_pkg::PageW-1:0]         page_q, page_d;
  logic [fpr_pkg::CountW-1:0]        count_q, count_d;
  logic [fpr_pkg::TimeW-1:0]         time_now_q, time_now_d;
  logic [fpr_pkg::FrameW-1:0]        frames_used_q, frames_used_d;
  logic [fpr_pkg::NumPages-1:0]      resident_q, resident_d;
  logic [fpr_pkg::NumPages-1:0]      written_q, written_d;
  logic [fpr_pkg::PageW:0]           scan_cnt_q, scan_cnt_d;
  logic                              rd_valid_q;
  logic                              done_q, done_d;
  logic                              fault_q, fault_d;
  logic                              replaced_q, replaced_d;
  logic [fpr_pkg::PageW-1:0]         victim_q, victim_d;
  logic [fpr_pkg::CountW-1:0]        ref_count_q, ref_count_d;

  logic                              ram_we;
  logic [fpr_pkg::PageW-1:0]         ram_waddr;
  logic [fpr_pkg::EntryW-1:0]        ram_wdata;
  logic [fpr_pkg::PageW-1:0]         ram_raddr;
  logic [fpr_pkg::EntryW-1:0]        ram_rdata;

  logic [fpr_pkg::CountW-1:0]        rd_count;
  logic [fpr_pkg::TimeW-1:0]         rd_time;
  logic [fpr_pkg::CountW-1:0]        count_new;
  logic [fpr_pkg::FrameW-1:0]        frame_limit;
  logic [fpr_pkg::PageW-1:0]         scan_idx;
  logic [fpr_pkg::PageW-1:0]         victim_idx;
  fpr_pkg::scan_ctrl_t               scan_ctrl;
  logic                              accept;

  assign busy   = (state_q != S_IDLE);
  assign accept = start && !busy;

  // Page table RAM: reference count and last use time of each page.
  fpr_ram #(
    .Width (fpr_pkg::EntryW),
    .Depth (fpr_pkg::NumPages)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Entries never written read as zero.
  assign rd_count  = rd_valid_q ? ram_rdata[fpr_pkg::EntryW-1:fpr_pkg::TimeW] : '0;
  assign rd_time   = rd_valid_q ? ram_rdata[fpr_pkg::TimeW-1:0] : '0;
  assign count_new = fpr_pkg::bump(rd_count);

  // The scan compares the record read in the previous cycle.
  assign scan_idx = fpr_pkg::PageW'(scan_cnt_q - 1'b1);
  assign ram_raddr = (state_q == S_SCAN) ? scan_cnt_q[fpr_pkg::PageW-1:0] : page_i;

  // Effective number of frames, clamped to one through the pool size.
  always_comb begin
    if (frame_cnt_q == '0) begin
      frame_limit = fpr_pkg::FrameW'(1);
    end else if (32'(frame_cnt_q) > 32'(fpr_pkg::MaxFrames)) begin
      frame_limit = fpr_pkg::FrameW'(fpr_pkg::MaxFrames);
    end else begin
      frame_limit = fpr_pkg::FrameW'(frame_cnt_q);
    end
  end

  fpr_victim_scan u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (scan_ctrl),
    .policy_i   (policy_q),
    .time_now_i (time_now_q),
    .idx_i      (scan_idx),
    .resident_i (resident_q[scan_idx]),
    .count_i    (rd_count),
    .time_i     (rd_time),
    .victim_o   (victim_idx)
  );

  // Configuration writes.
  always_comb begin
    policy_d    = policy_q;
    frame_cnt_d = frame_cnt_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        fpr_pkg::CfgPolicy: policy_d    = cfg_wdata_i[0];
        fpr_pkg::CfgFrames: frame_cnt_d = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Sequencer: look up, optional victim scan, write back and report.
  always_comb begin
    state_d       = state_q;
    page_d        = page_q;
    count_d       = count_q;
    time_now_d    = time_now_q;
    frames_used_d = frames_used_q;
    resident_d    = resident_q;
    written_d     = written_q;
    scan_cnt_d    = scan_cnt_q;
    done_d        = 1'b0;
    fault_d       = fault_q;
    replaced_d    = replaced_q;
    victim_d      = victim_q;
    ref_count_d   = ref_count_q;
    ram_we        = 1'b0;
    ram_waddr     = page_q;
    ram_wdata     = {count_new, time_now_q};
    scan_ctrl     = '0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          page_d  = page_i;
          state_d = S_LOOK;
        end
      end
      S_LOOK: begin
        count_d = count_new;
        if (resident_q[page_q]) begin
          // Hit: raise the count and record the time.
          ram_we                = 1'b1;
          written_d[page_q]     = 1'b1;
          time_now_d            = time_now_q + 1'b1;
          done_d                = 1'b1;
          fault_d               = 1'b0;
          replaced_d            = 1'b0;
          victim_d              = '0;
          ref_count_d           = count_new;
          state_d               = S_IDLE;
        end else if (frames_used_q >= frame_limit) begin
          // Miss with all frames taken: search for a victim.
          scan_ctrl.clear = 1'b1;
          scan_cnt_d      = '0;
          state_d         = S_SCAN;
        end else begin
          // Miss with a free frame.
          ram_we                = 1'b1;
          written_d[page_q]     = 1'b1;
          resident_d[page_q]    = 1'b1;
          frames_used_d         = frames_used_q + 1'b1;
          time_now_d            = time_now_q + 1'b1;
          done_d                = 1'b1;
          fault_d               = 1'b1;
          replaced_d            = 1'b0;
          victim_d              = '0;
          ref_count_d           = count_new;
          state_d               = S_IDLE;
        end
      end
      S_SCAN: begin
        scan_ctrl.step = (scan_cnt_q != '0);
        scan_cnt_d     = scan_cnt_q + 1'b1;
        if (scan_cnt_q == (fpr_pkg::PageW + 1)'(fpr_pkg::NumPages)) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        // Evict the chosen page and bring in the missing one.
        ram_we                 = 1'b1;
        ram_wdata              = {count_q, time_now_q};
        written_d[page_q]      = 1'b1;
        resident_d[victim_idx] = 1'b0;
        resident_d[page_q]     = 1'b1;
        time_now_d             = time_now_q + 1'b1;
        done_d                 = 1'b1;
        fault_d                = 1'b1;
        replaced_d             = 1'b1;
        victim_d               = victim_idx;
        ref_count_d            = count_q;
        state_d                = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      policy_q      <= fpr_pkg::PolicyLfu;
      frame_cnt_q   <= fpr_pkg::FrameCfgW'(3);
      time_now_q    <= '0;
      frames_used_q <= '0;
      resident_q    <= '0;
      written_q     <= '0;
      scan_cnt_q    <= '0;
      rd_valid_q    <= 1'b0;
      done_q        <= 1'b0;
    end else begin
      state_q       <= state_d;
      policy_q      <= policy_d;
      frame_cnt_q   <= frame_cnt_d;
      time_now_q    <= time_now_d;
      frames_used_q <= frames_used_d;
      resident_q    <= resident_d;
      written_q     <= written_d;
      scan_cnt_q    <= scan_cnt_d;
      rd_valid_q    <= written_q[ram_raddr];
      done_q        <= done_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    page_q      <= page_d;
    count_q     <= count_d;
    fault_q     <= fault_d;
    replaced_q  <= replaced_d;
    victim_q    <= victim_d;
    ref_count_q <= ref_count_d;
  end

  assign done_o        = done_q;
  assign fault_o       = fault_q;
  assign replaced_o    = replaced_q;
  assign victim_page_o = victim_q;
  assign ref_count_o   = ref_count_q;

endmodule

// ===== test/frequency_page_replacement_test.sv =====
// Self-checking testbench of the frequency page replacement block.
`timescale 1ns / 100ps

module frequency_page_replacement_test;
  import fpr_pkg::*;

  localparam int unsigned CycleLimit = 2_000_000;
  localparam int unsigned TailCycles = 2 * NumPages + 8;
  localparam int unsigned HotRefs    = 20;

  // Kinds of entries in the list of pending work.
  typedef enum logic [1:0] {
    OpPage,
    OpCfg,
    OpDrain
  } op_kind_e;

  typedef struct {
    op_kind_e           kind;
    logic [PageW-1:0]   page;
    logic [CfgIdxW-1:0] idx;
    logic [CfgDataW-1:0] data;
    int unsigned        gap;
  } op_t;

  typedef struct packed {
    logic              fault;
    logic              replaced;
    logic [PageW-1:0]  victim;
    logic [CountW-1:0] count;
  } lookup_t;

  // Clock, reset and block inputs, all known from time zero.
  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                start       = 1'b0;
  logic [PageW-1:0]    page_i      = '0;
  logic                cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i   = CfgPolicy;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;

  logic                busy;
  logic                done_o;
  logic                fault_o;
  logic                replaced_o;
  logic [PageW-1:0]    victim_page_o;
  logic [CountW-1:0]   ref_count_o;

  // Pending work and the lookups expected back from the block.
  op_t         work_q[$];
  lookup_t     lookup_q[$];
  int unsigned gap_cnt   = 0;
  int unsigned cycle_cnt = 0;
  bit          idling    = 1'b1;
  bit          failed    = 1'b0;

  // Shadow copy of the page table and the registers.
  logic                 pol_mode;
  logic [FrameCfgW-1:0] frames_cfg;
  logic                 resident [NumPages];
  logic [CountW-1:0]    use_cnt  [NumPages];
  logic [TimeW-1:0]     last_use [NumPages];
  int unsigned          frames_used;
  logic [TimeW-1:0]     now;

  frequency_page_replacement u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .page_i        (page_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .done_o        (done_o),
    .fault_o       (fault_o),
    .replaced_o    (replaced_o),
    .victim_page_o (victim_page_o),
    .ref_count_o   (ref_count_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Reference one page in the shadow table and return the expected outcome.
  function automatic lookup_t lookup_page(input logic [PageW-1:0] pg);
    lookup_t           r;
    int unsigned       lim;
    int                best;
    logic [CountW-1:0] best_cnt;
    logic [TimeW-1:0]  best_age;
    logic [TimeW-1:0]  age;
    bit                take;
    r        = '0;
    best     = -1;
    best_cnt = '0;
    best_age = '0;
    lim = (frames_cfg == 0) ? 1 : ((frames_cfg > MaxFrames) ? MaxFrames : frames_cfg);
    if (!resident[pg]) begin
      r.fault = 1'b1;
      if (frames_used >= lim) begin
        // Victim search: count first, then the oldest reference, then lowest page.
        for (int i = 0; i < NumPages; i++) begin
          if (resident[i]) begin
            age = now - last_use[i];
            if (best < 0) begin
              take = 1'b1;
            end else if (use_cnt[i] == best_cnt) begin
              take = age > best_age;
            end else if (pol_mode == PolicyLfu) begin
              take = use_cnt[i] < best_cnt;
            end else begin
              take = use_cnt[i] > best_cnt;
            end
            if (take) begin
              best     = i;
              best_cnt = use_cnt[i];
              best_age = age;
            end
          end
        end
        if (best >= 0) begin
          resident[best] = 1'b0;
          frames_used--;
          r.replaced = 1'b1;
          r.victim   = best[PageW-1:0];
        end
      end
      resident[pg] = 1'b1;
      frames_used++;
    end
    // The count saturates and survives eviction.
    if (use_cnt[pg] != CountMax) begin
      use_cnt[pg] = use_cnt[pg] + 1'b1;
    end
    last_use[pg] = now;
    r.count      = use_cnt[pg];
    now          = now + 1'b1;
    return r;
  endfunction

  task automatic add_page(input logic [PageW-1:0] pg);
    op_t op;
    op.kind = OpPage;
    op.page = pg;
    op.idx  = CfgPolicy;
    op.data = '0;
    op.gap  = (idling && $urandom_range(0, 3) == 0) ? $urandom_range(1, 13) : 0;
    work_q.insert(work_q.size(), op);
  endtask

  task automatic add_cfg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    op_t op;
    op.kind = OpCfg;
    op.page = '0;
    op.idx  = idx;
    op.data = data;
    op.gap  = 0;
    work_q.insert(work_q.size(), op);
  endtask

  task automatic add_drain();
    op_t op;
    op.kind = OpDrain;
    op.page = '0;
    op.idx  = CfgPolicy;
    op.data = '0;
    op.gap  = 0;
    work_q.insert(work_q.size(), op);
  endtask

  // Driver: issues page words, and register writes only while the block is idle.
  always @(posedge clk_i) begin
    logic                nxt_start;
    logic [PageW-1:0]    nxt_page;
    logic                nxt_we;
    logic [CfgIdxW-1:0]  nxt_idx;
    logic [CfgDataW-1:0] nxt_wdata;
    logic                idle;
    op_t                 op;
    nxt_start = start;
    nxt_page  = page_i;
    nxt_we    = 1'b0;
    nxt_idx   = cfg_idx_i;
    nxt_wdata = cfg_wdata_i;
    idle = !start && !busy && !done_o && (lookup_q.size() == 0);
    if (rst_ni && !(start && busy)) begin
      nxt_start = 1'b0;
      if (work_q.size() != 0) begin
        op = work_q[0];
        if (gap_cnt < op.gap) begin
          gap_cnt++;
        end else begin
          case (op.kind)
            OpPage: begin
              nxt_start = 1'b1;
              nxt_page  = op.page;
              void'(work_q.pop_front());
              gap_cnt = 0;
            end
            OpCfg: begin
              if (idle) begin
                nxt_we    = 1'b1;
                nxt_idx   = op.idx;
                nxt_wdata = op.data;
                void'(work_q.pop_front());
              end
            end
            default: begin
              if (idle) begin
                void'(work_q.pop_front());
              end
            end
          endcase
        end
      end
    end
    start       <= nxt_start;
    page_i      <= nxt_page;
    cfg_we_i    <= nxt_we;
    cfg_idx_i   <= nxt_idx;
    cfg_wdata_i <= nxt_wdata;
  end

  // Monitor: checks each result word, then tracks writes and accepted words.
  always @(posedge clk_i) begin
    lookup_t got;
    lookup_t want;
    if (rst_ni) begin
      if (done_o) begin
        got = '{fault_o, replaced_o, victim_page_o, ref_count_o};
        if (lookup_q.size() == 0) begin
          $error("result word with no page reference pending");
          failed = 1'b1;
        end else begin
          want = lookup_q.pop_front();
          if (got.fault !== want.fault) begin
            $error("fault: expected %0d, actual %0d", want.fault, got.fault);
            failed = 1'b1;
          end
          if (got.replaced !== want.replaced) begin
            $error("replaced: expected %0d, actual %0d", want.replaced, got.replaced);
            failed = 1'b1;
          end
          if (got.victim !== want.victim) begin
            $error("victim_page: expected %0d, actual %0d", want.victim, got.victim);
            failed = 1'b1;
          end
          if (got.count !== want.count) begin
            $error("ref_count: expected %0d, actual %0d", want.count, got.count);
            failed = 1'b1;
          end
        end
      end
      if (cfg_we_i) begin
        if (cfg_idx_i == CfgPolicy) begin
          pol_mode = cfg_wdata_i[0];
        end else begin
          frames_cfg = cfg_wdata_i;
        end
      end
      if (start && !busy) begin
        lookup_q.insert(lookup_q.size(), lookup_page(page_i));
      end
    end
  end

  // Watchdog on the whole run.
  initial begin
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    int unsigned ph;
    int unsigned n;
    int unsigned fr;
    int unsigned lim;
    int unsigned base;
    int unsigned pg;
    logic        pol;

    pol_mode    = PolicyLfu;
    frames_cfg  = FrameCfgW'(3);
    frames_used = 0;
    now         = '0;
    for (int i = 0; i < NumPages; i++) begin
      resident[i] = 1'b0;
      use_cnt[i]  = '0;
      last_use[i] = '0;
    end

    // Directed part, reset settings: fill, ties on count, hits, evictions.
    add_page(4'd0);
    add_page(4'd1);
    add_page(4'd2);
    add_page(4'd3);
    add_page(4'd1);
    add_page(4'd1);
    add_page(4'd15);
    add_page(4'd0);
    // Most frequently used, frame count above the maximum.
    add_cfg(CfgPolicy, CfgDataW'({$urandom(), PolicyMfu}));
    add_cfg(CfgFrames, FrameCfgW'(15));
    for (int i = 4; i < 12; i++) begin
      add_page(PageW'(i));
    end
    // Frame count zero, far below the pages resident.
    add_cfg(CfgFrames, FrameCfgW'(0));
    add_page(4'd12);
    add_page(4'd12);
    add_page(4'd13);
    add_page(4'd14);

    // Random phases, each under its own register setting.
    for (ph = 0; ph < 15; ph++) begin
      case (ph)
        0:       fr = 1;
        1:       fr = 8;
        2:       fr = 0;
        3:       fr = 15;
        4:       fr = 2;
        default: fr = $urandom_range(0, 15);
      endcase
      pol    = (ph < 4) ? ph[0] : 1'($urandom_range(0, 1));
      idling = (ph % 3) != 2;
      add_cfg(CfgPolicy, CfgDataW'({$urandom(), pol}));
      add_cfg(CfgFrames, FrameCfgW'(fr));
      lim  = (fr == 0) ? 1 : ((fr > MaxFrames) ? MaxFrames : fr);
      base = $urandom_range(0, NumPages - 1);
      for (n = 0; n < 100; n++) begin
        // Mostly a hot set just above the frame count, so hits and evictions mix.
        if ($urandom_range(0, 9) < 7) begin
          pg = (base + $urandom_range(0, lim)) % NumPages;
        end else begin
          pg = $urandom_range(0, NumPages - 1);
        end
        add_page(PageW'(pg));
        if ($urandom_range(0, 49) == 0) begin
          add_drain();
        end
      end
    end

    // Last part without gaps: make one page hot, then mix.
    idling = 1'b0;
    add_cfg(CfgPolicy, CfgDataW'({$urandom(), PolicyLfu}));
    add_cfg(CfgFrames, FrameCfgW'(MaxFrames));
    for (n = 0; n < HotRefs; n++) begin
      add_page(4'd9);
    end
    add_cfg(CfgPolicy, CfgDataW'({$urandom(), PolicyMfu}));
    for (n = 0; n < 80; n++) begin
      pg = ($urandom_range(0, 3) == 0) ? 9 : $urandom_range(0, NumPages - 1);
      add_page(PageW'(pg));
    end

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (work_q.size() != 0 || start || done_o || lookup_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (TailCycles) @(posedge clk_i);
    if (!failed && lookup_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/fpr_pkg.sv
rtl/fpr_ram.sv
rtl/fpr_victim_scan.sv
rtl/frequency_page_replacement.sv
test/frequency_page_replacement_test.sv
